/* rtl/core/wccq_pkg.sv */
package wccq_pkg;

  // Field widths
  localparam int ID_W    = 8;
  localparam int ADDR_W  = 7;
  localparam int VAL_W   = 12;
  localparam int KEY_W   = ID_W + ADDR_W + 1;
  localparam int ENTRY_W = KEY_W + VAL_W;
  localparam int LIMIT_W = 8;
  localparam int OFF_W   = 9;
  localparam int OCC_W   = 6;

  // Queue storage
  localparam int ENTRY_DEPTH_DEF = 32;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Packet sizing
  localparam logic [VAL_W-1:0]   NARROW_MASK  = VAL_W'(8'hff);
  localparam logic [OFF_W-1:0]   NARROW_BYTES = OFF_W'(4);
  localparam logic [OFF_W-1:0]   WIDE_BYTES   = OFF_W'(5);
  localparam int                 PACKET_BUF_BYTES = 56;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(PACKET_BUF_BYTES - 4);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_LIMIT = '0;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DRAINED = 2'd1,
    KIND_NONE    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN_CHK,
    S_DRAIN_EMIT
  } state_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic               drain;
    logic [ID_W-1:0]    servo_id;
    logic [ADDR_W-1:0]  reg_addr;
    logic               wide;
    logic [VAL_W-1:0]   value;
    logic [LIMIT_W-1:0] bytes_used;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    kind_t              kind;
    logic               merged;
    logic               dropped;
    logic [ID_W-1:0]    servo_id;
    logic [ADDR_W-1:0]  reg_addr;
    logic               wide;
    logic [VAL_W-1:0]   value;
    logic [OFF_W-1:0]   end_offset;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } res_t;

endpackage

/* rtl/core/wccq_front.sv */
module wccq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [wccq_pkg::ID_W-1:0]  in_servo_id,
  input  logic [wccq_pkg::ADDR_W-1:0] in_reg_addr,
  input  logic                       in_wide,
  input  logic [wccq_pkg::VAL_W-1:0] in_write_value,
  input  logic [wccq_pkg::LIMIT_W-1:0] in_bytes_used,
  output logic                       cmd_valid,
  output wccq_pkg::cmd_t             cmd,
  input  logic                       cmd_pop
);

  wccq_pkg::cmd_t                        q_r [wccq_pkg::CMDQ_DEPTH];
  logic [wccq_pkg::CMDQ_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [wccq_pkg::CMDQ_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [wccq_pkg::CMDQ_CNT_W-1:0]       fill_r, fill_nxt;
  wccq_pkg::cmd_t                        cls;
  logic                                  push;
  logic                                  pop;

  // Classify: narrow writes keep only the low byte
  always_comb begin
    cls.drain      = in_mode;
    cls.servo_id   = in_servo_id;
    cls.reg_addr   = in_reg_addr;
    cls.wide       = in_wide;
    cls.value      = in_wide ? in_write_value : (in_write_value & wccq_pkg::NARROW_MASK);
    cls.bytes_used = in_bytes_used;
  end

  assign in_stall  = (fill_r == wccq_pkg::CMDQ_CNT_W'(wccq_pkg::CMDQ_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/core/wccq_back.sv */
module wccq_back #(
  parameter int ENTRY_DEPTH = wccq_pkg::ENTRY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [wccq_pkg::LIMIT_W-1:0] limit,
  input  logic                         cmd_valid,
  input  wccq_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         res_valid,
  output wccq_pkg::res_t               res,
  input  logic                         res_stall
);

  localparam int IDX_W = $clog2(ENTRY_DEPTH);
  localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(ENTRY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ENTRY_DEPTH);

  // Entry memory, undefined until written
  logic [wccq_pkg::ENTRY_W-1:0] mem [ENTRY_DEPTH];
  logic [wccq_pkg::ENTRY_W-1:0] rdata_r;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;

  wccq_pkg::state_t             state_r, state_nxt;
  wccq_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             slot_r, slot_nxt;
  logic [wccq_pkg::OFF_W-1:0]   offset_r, offset_nxt;
  wccq_pkg::res_t               res_r, res_nxt;
  logic                         res_vld_r;
  logic                         res_load;

  logic [wccq_pkg::KEY_W-1:0]   cmd_key;
  logic [wccq_pkg::ENTRY_W-1:0] cmd_ent;
  logic                         res_free;
  logic                         hit;
  logic                         scan_end;
  logic                         full;
  logic                         drain_go;
  logic [wccq_pkg::OFF_W-1:0]   off_new;
  logic [CNT_W-1:0]             cnt_new;
  logic [IDX_W-1:0]             head_new;
  logic [IDX_W-1:0]             scan_slot;
  logic [IDX_W-1:0]             tail_slot;
  logic                         more;

  // Ring index add, both operands below the depth
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  // Shared conditions
  assign cmd_key   = {cmd_r.servo_id, cmd_r.reg_addr, cmd_r.wide};
  assign cmd_ent   = {cmd_key, cmd_r.value};
  assign res_free  = !res_vld_r || !res_stall;
  assign hit       = pend_r && (rdata_r[wccq_pkg::ENTRY_W-1:wccq_pkg::VAL_W] == cmd_key);
  assign scan_end  = (idx_r == count_r) && !hit;
  assign full      = (count_r == DEPTH_C);
  assign drain_go  = (count_r != '0) && (offset_r < {1'b0, limit});
  assign off_new   = offset_r + (rdata_r[wccq_pkg::VAL_W] ? wccq_pkg::WIDE_BYTES
                                                          : wccq_pkg::NARROW_BYTES);
  assign cnt_new   = count_r - 1'b1;
  assign head_new  = slot_add(head_r, IDX_W'(1));
  assign scan_slot = slot_add(head_r, idx_r[IDX_W-1:0]);
  assign tail_slot = slot_add(head_r, count_r[IDX_W-1:0]);
  assign more      = (cnt_new != '0) && (off_new < {1'b0, limit});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wccq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = cmd.drain ? wccq_pkg::S_DRAIN_CHK : wccq_pkg::S_SEARCH;
        end
      end
      wccq_pkg::S_SEARCH: begin
        if ((hit || scan_end) && res_free) begin
          state_nxt = wccq_pkg::S_IDLE;
        end
      end
      wccq_pkg::S_DRAIN_CHK: begin
        if (drain_go) begin
          state_nxt = wccq_pkg::S_DRAIN_EMIT;
        end else if (res_free) begin
          state_nxt = wccq_pkg::S_IDLE;
        end
      end
      wccq_pkg::S_DRAIN_EMIT: begin
        if (res_free && !more) begin
          state_nxt = wccq_pkg::S_IDLE;
        end
      end
      default: state_nxt = wccq_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    cmd_pop    = 1'b0;
    cmd_nxt    = cmd_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    slot_nxt   = slot_r;
    offset_nxt = offset_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_slot;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    res_load   = 1'b0;
    res_nxt    = '0;
    case (state_r)
      wccq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cmd_nxt    = cmd;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          offset_nxt = wccq_pkg::OFF_W'(cmd.bytes_used);
        end
      end
      wccq_pkg::S_SEARCH: begin
        if (hit || scan_end) begin
          if (res_free) begin
            res_load     = 1'b1;
            res_nxt.kind = wccq_pkg::KIND_ACK;
            res_nxt.last = 1'b1;
            pend_nxt     = 1'b0;
            if (hit) begin
              // replace value in place, queue position unchanged
              mem_we         = 1'b1;
              mem_waddr      = slot_r;
              res_nxt.merged = 1'b1;
              res_nxt.occupancy = wccq_pkg::OCC_W'(count_r);
            end else if (full) begin
              res_nxt.dropped   = 1'b1;
              res_nxt.occupancy = wccq_pkg::OCC_W'(count_r);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tail_slot;
              count_nxt = count_r + 1'b1;
              res_nxt.occupancy = wccq_pkg::OCC_W'(count_nxt);
            end
          end
        end else begin
          // read next occupied entry; the compare uses the registered read data in the next cycle
          mem_re    = 1'b1;
          mem_raddr = scan_slot;
          slot_nxt  = scan_slot;
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      wccq_pkg::S_DRAIN_CHK: begin
        if (drain_go) begin
          mem_re    = 1'b1;
          mem_raddr = head_r;
        end else if (res_free) begin
          res_load           = 1'b1;
          res_nxt.kind       = wccq_pkg::KIND_NONE;
          res_nxt.end_offset = offset_r;
          res_nxt.occupancy  = wccq_pkg::OCC_W'(count_r);
          res_nxt.last       = 1'b1;
        end
      end
      wccq_pkg::S_DRAIN_EMIT: begin
        if (res_free) begin
          res_load           = 1'b1;
          res_nxt.kind       = wccq_pkg::KIND_DRAINED;
          res_nxt.servo_id   = rdata_r[wccq_pkg::ENTRY_W-1 -: wccq_pkg::ID_W];
          res_nxt.reg_addr   = rdata_r[wccq_pkg::VAL_W+1 +: wccq_pkg::ADDR_W];
          res_nxt.wide       = rdata_r[wccq_pkg::VAL_W];
          res_nxt.value      = rdata_r[wccq_pkg::VAL_W-1:0];
          res_nxt.end_offset = off_new;
          res_nxt.occupancy  = wccq_pkg::OCC_W'(cnt_new);
          res_nxt.last       = !more;
          head_nxt           = head_new;
          count_nxt          = cnt_new;
          offset_nxt         = off_new;
          // prefetch the next head so one command leaves per cycle while the result is not stalled
          if (more) begin
            mem_re    = 1'b1;
            mem_raddr = head_new;
          end
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= wccq_pkg::S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      pend_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (!res_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    offset_r <= offset_nxt;
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_ent;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above queue depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) ||
                     (count_r == CNT_W'($past(count_r) + 1'b1)) ||
                     (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wccq_pkg::S_SEARCH) && mem_re |-> idx_r < count_r)
    else $error("search read beyond occupied entries");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wccq_pkg::S_DRAIN_EMIT |-> count_r != '0)
    else $error("drain pop from empty queue");

  a_drain_flags: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && (res_r.kind != wccq_pkg::KIND_ACK) |-> !res_r.merged && !res_r.dropped)
    else $error("drain result carries enqueue flags");

endmodule

/* rtl/core/write_coalescing_command_queue.sv */
// Channel   Direction  Handshake               Carries
// in_*      input      in_valid / in_stall     enqueue or drain request
// out_*     output     out_valid / out_stall   acknowledge, drained command or empty mark
// cfg_*     input      APB-style, pready high  packet_byte_limit at byte address 0
//
// Up to two requests wait in the front queue while the back end works on one.
// Enqueue: the command is picked up, then each queued entry is read and compared in turn; the
// result follows a match or the last compare, a scan paced by the single-read entry memory.
// Drain: head read first, then one command per cycle from the prefetched head unless stalled.
// Synchronous reset clears pointers and counts, sets the limit to 52; entries are not cleared.
// A stalled result holds the back end; the front keeps taking requests until its queue fills.
module write_coalescing_command_queue #(
  parameter int ENTRY_DEPTH = wccq_pkg::ENTRY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [wccq_pkg::ID_W-1:0]        in_servo_id,
  input  logic [wccq_pkg::ADDR_W-1:0]      in_reg_addr,
  input  logic                             in_wide,
  input  logic [wccq_pkg::VAL_W-1:0]       in_write_value,
  input  logic [wccq_pkg::LIMIT_W-1:0]     in_bytes_used,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic                             out_merged,
  output logic                             out_dropped,
  output logic [wccq_pkg::ID_W-1:0]        out_servo_id,
  output logic [wccq_pkg::ADDR_W-1:0]      out_reg_addr,
  output logic                             out_wide,
  output logic [wccq_pkg::VAL_W-1:0]       out_value,
  output logic [wccq_pkg::OFF_W-1:0]       out_end_offset,
  output logic [wccq_pkg::OCC_W-1:0]       out_occupancy,
  output logic                             out_last,
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wccq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wccq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wccq_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  logic [wccq_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                         limit_sel;
  logic                         cmd_valid;
  wccq_pkg::cmd_t               cmd;
  logic                         cmd_pop;
  wccq_pkg::res_t               res;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign limit_sel  = (cfg_paddr[wccq_pkg::CFG_ADDR_W-1:2] == wccq_pkg::REG_LIMIT);

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && limit_sel) begin
      limit_nxt = cfg_pwdata[wccq_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= wccq_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign cfg_prdata = limit_sel ? wccq_pkg::CFG_DATA_W'(limit_r) : '0;

  // Front: accept and classify
  wccq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_servo_id    (in_servo_id),
    .in_reg_addr    (in_reg_addr),
    .in_wide        (in_wide),
    .in_write_value (in_write_value),
    .in_bytes_used  (in_bytes_used),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back: merge search, append and drain
  wccq_back #(
    .ENTRY_DEPTH (ENTRY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  assign out_kind       = res.kind;
  assign out_merged     = res.merged;
  assign out_dropped    = res.dropped;
  assign out_servo_id   = res.servo_id;
  assign out_reg_addr   = res.reg_addr;
  assign out_wide       = res.wide;
  assign out_value      = res.value;
  assign out_end_offset = res.end_offset;
  assign out_occupancy  = res.occupancy;
  assign out_last       = res.last;

endmodule

/* dv/testbench.sv */
module testbench;

  localparam int QDEPTH     = wccq_pkg::ENTRY_DEPTH_DEF;
  localparam int MAX_POPS   = 64;
  localparam int N_DIRECTED = 17;
  localparam int N_PHASES   = 8;
  localparam int POOL_MAX   = 48;

  typedef logic [wccq_pkg::ID_W-1:0]       id_t;
  typedef logic [wccq_pkg::ADDR_W-1:0]     addr_t;
  typedef logic [wccq_pkg::VAL_W-1:0]      val_t;
  typedef logic [wccq_pkg::LIMIT_W-1:0]    limit_t;
  typedef logic [wccq_pkg::OFF_W-1:0]      off_t;
  typedef logic [wccq_pkg::OCC_W-1:0]      occ_t;
  typedef logic [wccq_pkg::ENTRY_W-1:0]    entry_t;
  typedef logic [wccq_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_DRAIN   = 1'b1
  } req_mode_t;

  // One request transaction as presented on the in_ channel
  typedef struct packed {
    req_mode_t mode;
    id_t       servo_id;
    addr_t     reg_addr;
    logic      wide;
    val_t      value;
    limit_t    bytes_used;
  } req_t;

  // Directed row: request plus an optional hand-written single result
  typedef struct packed {
    req_t            req;
    logic            typed;
    wccq_pkg::kind_t kind;
    logic            merged;
    logic            dropped;
    off_t            end_offset;
    occ_t            occupancy;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid       = 1'b0;
  logic      in_stall;
  logic      in_mode        = 1'b0;
  id_t       in_servo_id    = '0;
  addr_t     in_reg_addr    = '0;
  logic      in_wide        = 1'b0;
  val_t      in_write_value = '0;
  limit_t    in_bytes_used  = '0;

  logic      out_valid;
  logic      out_stall      = 1'b0;
  logic [1:0] out_kind;
  logic      out_merged;
  logic      out_dropped;
  id_t       out_servo_id;
  addr_t     out_reg_addr;
  logic      out_wide;
  val_t      out_value;
  off_t      out_end_offset;
  occ_t      out_occupancy;
  logic      out_last;

  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [wccq_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  cfg_data_t                       cfg_pwdata  = '0;
  cfg_data_t                       cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the queue and the limit register
  entry_t shadow_store [QDEPTH];
  int     shadow_head;
  int     shadow_count;
  limit_t shadow_limit;

  wccq_pkg::res_t pending_results [$];
  int   fail_count  = 0;
  int   gap_odds    = 0;
  bit   quiet_tail  = 1'b0;
  int   stall_left  = 0;

  write_coalescing_command_queue i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_servo_id    (in_servo_id),
    .in_reg_addr    (in_reg_addr),
    .in_wide        (in_wide),
    .in_write_value (in_write_value),
    .in_bytes_used  (in_bytes_used),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_merged     (out_merged),
    .out_dropped    (out_dropped),
    .out_servo_id   (out_servo_id),
    .out_reg_addr   (out_reg_addr),
    .out_wide       (out_wide),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_occupancy  (out_occupancy),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always #5 clk = ~clk;

  // Append one expected result at the tail of the list
  function automatic void queue_result(input wccq_pkg::res_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void predict_queue_results(input req_t r);
    entry_t         ent;
    val_t           val;
    off_t           offset;
    int             n;
    bit             hit;
    wccq_pkg::res_t res;
    res = '0;
    res.last = 1'b1;
    if (r.mode == REQ_ENQUEUE) begin
      val = r.wide ? r.value : (r.value & wccq_pkg::NARROW_MASK);
      ent = {r.servo_id, r.reg_addr, r.wide, val};
      hit = 1'b0;
      // same id, address and width: overwrite the value in place
      for (int i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_store[(shadow_head + i) % QDEPTH][wccq_pkg::ENTRY_W-1:wccq_pkg::VAL_W]
            == ent[wccq_pkg::ENTRY_W-1:wccq_pkg::VAL_W]) begin
          shadow_store[(shadow_head + i) % QDEPTH] = ent;
          hit = 1'b1;
        end
      end
      res.kind = wccq_pkg::KIND_ACK;
      if (hit) begin
        res.merged = 1'b1;
      end else if (shadow_count >= QDEPTH) begin
        res.dropped = 1'b1;
      end else begin
        shadow_store[(shadow_head + shadow_count) % QDEPTH] = ent;
        shadow_count++;
      end
      res.occupancy = occ_t'(shadow_count);
      queue_result(res);
    end else begin
      offset = off_t'(r.bytes_used);
      n = 0;
      // pop in order while the next command still starts below the limit
      while (shadow_count > 0 && offset < off_t'(shadow_limit) && n < MAX_POPS) begin
        ent = shadow_store[shadow_head];
        offset += ent[wccq_pkg::VAL_W] ? wccq_pkg::WIDE_BYTES : wccq_pkg::NARROW_BYTES;
        shadow_head = (shadow_head + 1) % QDEPTH;
        shadow_count--;
        res = '0;
        res.kind = wccq_pkg::KIND_DRAINED;
        {res.servo_id, res.reg_addr, res.wide, res.value} = ent;
        res.end_offset = offset;
        res.occupancy = occ_t'(shadow_count);
        queue_result(res);
        n++;
      end
      if (n == 0) begin
        res.kind = wccq_pkg::KIND_NONE;
        res.end_offset = offset;
        res.occupancy = occ_t'(shadow_count);
        queue_result(res);
      end else begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic void check_field(input string fname, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: result field %s mismatch, expected %0d, actual %0d",
               $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // Present one request, hold it until taken, then predict its results
  task automatic send_request(input req_t r);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= r.mode;
    in_servo_id    <= r.servo_id;
    in_reg_addr    <= r.reg_addr;
    in_wide        <= r.wide;
    in_write_value <= r.value;
    in_bytes_used  <= r.bytes_used;
    do @(posedge clk); while (in_stall);
    predict_queue_results(r);
  endtask

  // Let every outstanding result come back, then a margin for the back end
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_byte_limit(input limit_t lim);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {wccq_pkg::REG_LIMIT, 2'b00};
    cfg_pwdata  <= cfg_data_t'(lim);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow_limit = lim;
  endtask

  // Result stall: random bursts of back-pressure and free-running stretches
  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 1) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 14);
    end else begin
      out_stall  <= 1'b0;
      stall_left = $urandom_range(1, 40);
    end
  end

  // Compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin
    wccq_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d offset %0d",
                 $time, out_kind, out_end_offset);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",       want.kind,       out_kind);
        check_field("merged",     want.merged,     out_merged);
        check_field("dropped",    want.dropped,    out_dropped);
        check_field("servo_id",   want.servo_id,   out_servo_id);
        check_field("reg_addr",   want.reg_addr,   out_reg_addr);
        check_field("wide",       want.wide,       out_wide);
        check_field("value",      want.value,      out_value);
        check_field("end_offset", want.end_offset, out_end_offset);
        check_field("occupancy",  want.occupancy,  out_occupancy);
        check_field("last",       want.last,       out_last);
      end
    end
  end

  initial begin
    dir_row_t       dir_rows [N_DIRECTED];
    limit_t         phase_limit [N_PHASES];
    int             phase_items [N_PHASES];
    int             phase_drain [N_PHASES];
    int             phase_gap [N_PHASES];
    id_t            pool_id [POOL_MAX];
    addr_t          pool_addr [POOL_MAX];
    logic           pool_wide [POOL_MAX];
    int             pool_n;
    int             k;
    req_t           r;
    wccq_pkg::res_t typed_res;

    // limit at reset is 52 for the whole directed part
    dir_rows = '{
      // drain of an empty queue, both ends of bytes_used
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd0},   1'b1, wccq_pkg::KIND_NONE,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd255}, 1'b1, wccq_pkg::KIND_NONE,
        1'b0, 1'b0, 9'd255, 6'd0},
      // field extremes; narrow keeps the low byte only
      '{'{REQ_ENQUEUE, 8'h00, 7'h00, 1'b0, 12'hfff, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd1},
      '{'{REQ_ENQUEUE, 8'hff, 7'h7f, 1'b1, 12'hfff, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd2},
      // same key merges, other width does not
      '{'{REQ_ENQUEUE, 8'h00, 7'h00, 1'b0, 12'h0a5, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b1, 1'b0, 9'd0,   6'd2},
      '{'{REQ_ENQUEUE, 8'h00, 7'h00, 1'b1, 12'h123, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd3},
      '{'{REQ_ENQUEUE, 8'hff, 7'h7f, 1'b1, 12'h000, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b1, 1'b0, 9'd0,   6'd3},
      '{'{REQ_ENQUEUE, 8'hff, 7'h7f, 1'b0, 12'h800, 8'd0},   1'b1, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd4},
      // offset already at or past the limit: nothing leaves
      '{'{REQ_DRAIN,   8'hff, 7'h7f, 1'b1, 12'hfff, 8'd52},  1'b1, wccq_pkg::KIND_NONE,
        1'b0, 1'b0, 9'd52,  6'd4},
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd255}, 1'b1, wccq_pkg::KIND_NONE,
        1'b0, 1'b0, 9'd255, 6'd4},
      // one below the limit: a single command
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd51},  1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_ENQUEUE, 8'h5a, 7'h2a, 1'b1, 12'habc, 8'd0},   1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_ENQUEUE, 8'ha5, 7'h55, 1'b0, 12'h3c3, 8'd0},   1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0},
      // multi-command drain empties the queue
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd0},   1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd0},   1'b1, wccq_pkg::KIND_NONE,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_ENQUEUE, 8'h80, 7'h40, 1'b0, 12'h07f, 8'd0},   1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0},
      '{'{REQ_DRAIN,   8'h00, 7'h00, 1'b0, 12'h000, 8'd48},  1'b0, wccq_pkg::KIND_ACK,
        1'b0, 1'b0, 9'd0,   6'd0}
    };

    // limits per phase, extremes and a zero limit among them
    phase_limit = '{8'd8, 8'd255, 8'd0, limit_t'($urandom_range(8, 255)), 8'd52,
                    limit_t'($urandom_range(8, 255)), 8'd255,
                    limit_t'($urandom_range(8, 255))};
    phase_items = '{64, 64, 10, 64, 64, 64, 64, 64};
    phase_drain = '{4, 14, 3, 6, 3, 10, 2, 4};
    phase_gap   = '{3, 0, 4, 5, 2, 0, 3, 0};

    shadow_head  = 0;
    shadow_count = 0;
    shadow_limit = wccq_pkg::LIMIT_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    gap_odds = 3;
    for (int d = 0; d < N_DIRECTED; d++) begin
      send_request(dir_rows[d].req);
      if (dir_rows[d].typed) begin
        typed_res            = '0;
        typed_res.kind       = dir_rows[d].kind;
        typed_res.merged     = dir_rows[d].merged;
        typed_res.dropped    = dir_rows[d].dropped;
        typed_res.end_offset = dir_rows[d].end_offset;
        typed_res.occupancy  = dir_rows[d].occupancy;
        typed_res.last       = 1'b1;
        pending_results[pending_results.size() - 1] = typed_res;
      end
    end

    // random phases: keys mostly from a small pool so merges and a full queue occur
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_byte_limit(phase_limit[p]);
      gap_odds = phase_gap[p];
      if (p == N_PHASES - 1) quiet_tail = 1'b1;
      pool_n = (p == 1) ? POOL_MAX : $urandom_range(3, 40);
      for (int j = 0; j < pool_n; j++) begin
        pool_id[j]   = id_t'($urandom_range(0, 255));
        pool_addr[j] = addr_t'($urandom_range(0, 127));
        pool_wide[j] = 1'($urandom_range(0, 1));
      end
      for (int it = 0; it < phase_items[p]; it++) begin
        r = '0;
        if ($urandom_range(0, phase_drain[p] - 1) == 0) begin
          r.mode = REQ_DRAIN;
          r.bytes_used = ($urandom_range(0, 7) == 0) ? limit_t'($urandom_range(0, 255))
                                                     : limit_t'($urandom_range(0, 48));
        end else begin
          r.mode = REQ_ENQUEUE;
          if ($urandom_range(0, 3) == 0) begin
            r.servo_id = id_t'($urandom_range(0, 255));
            r.reg_addr = addr_t'($urandom_range(0, 127));
            r.wide     = 1'($urandom_range(0, 1));
          end else begin
            k = $urandom_range(0, pool_n - 1);
            r.servo_id = pool_id[k];
            r.reg_addr = pool_addr[k];
            r.wide     = pool_wide[k];
          end
          r.value = val_t'($urandom_range(0, 4095));
          r.bytes_used = limit_t'($urandom_range(0, 255));
        end
        send_request(r);
      end
    end

    // drain the pipeline and allow for trailing results
    wait_idle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[write_coalescing_command_queue] OK");
    end else begin
      $display("[write_coalescing_command_queue] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #50000000;
    $display("[write_coalescing_command_queue] ERROR");
    $finish;
  end

endmodule
